// ----- rtl/core/rmt_pkg.sv -----
// Shared types and constants for the running median tracker.
package rmt_pkg;

  localparam int SAMPLE_W = 16;
  localparam int COUNT_W  = 11;

  // One input beat.
  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic                last_item;
  } rmt_in_t;

  // One result beat.
  typedef struct packed {
    logic [SAMPLE_W-1:0] median;
    logic [COUNT_W-1:0]  count;
    logic                overflow;
  } rmt_out_t;

  // Lower middle and the entry just above it, as read out of the cell row.
  typedef struct packed {
    logic [SAMPLE_W-1:0] lo;
    logic [SAMPLE_W-1:0] hi;
  } rmt_pair_t;

  // Commands broadcast to every cell.
  typedef struct packed {
    logic insert;
    logic advance;
    logic clear;
  } rmt_ctl_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_DONE
  } rmt_state_t;

endpackage

// ----- rtl/core/rmt_cell.sv -----
// One compare-and-shift cell of the sorted sample row.
module rmt_cell (
  input  logic                            clk,
  input  logic                            rst,
  input  logic [rmt_pkg::SAMPLE_W-1:0]    sample,
  input  rmt_pkg::rmt_ctl_t               ctl,
  input  logic                            home,
  input  logic [rmt_pkg::SAMPLE_W-1:0]    left_val,
  input  logic                            left_gt,
  input  logic                            tail_in,
  input  logic                            sel_in,
  input  logic [rmt_pkg::SAMPLE_W-1:0]    right_val,
  output logic [rmt_pkg::SAMPLE_W-1:0]    val,
  output logic                            gt,
  output logic                            tail,
  output logic                            sel,
  output rmt_pkg::rmt_pair_t              leaf
);
  import rmt_pkg::*;

  // Strictly greater, so a new sample lands after held samples of equal value.
  assign gt = val > sample;

  // The held value moves one place up when the new sample goes in below it.
  // The cell at the fill pointer always takes a value.
  always_ff @(posedge clk) begin
    if (ctl.insert && (tail || gt)) begin
      val <= left_gt ? left_val : sample;
    end
  end

  // Fill pointer and lower-middle marker travel along the row one cell a step.
  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      tail <= home;
      sel  <= home;
    end else begin
      if (ctl.insert) begin
        tail <= tail_in;
      end
      if (ctl.advance) begin
        sel <= sel_in;
      end
    end
  end

  // Only the marked cell drives its value and its upper neighbor into the tree.
  assign leaf.lo = sel ? val : '0;
  assign leaf.hi = sel ? right_val : '0;

endmodule

// ----- rtl/core/rmt_or_tree.sv -----
// Registered OR tree that gathers the marked pair out of the cell row.
module rmt_or_tree #(
  parameter int N = 1024
) (
  input  logic               clk,
  input  rmt_pkg::rmt_pair_t leaf [N],
  output rmt_pkg::rmt_pair_t root
);
  import rmt_pkg::*;

  localparam int DEPTH = $clog2(N);
  localparam int P     = 1 << DEPTH;

  rmt_pair_t leaf_w [P];
  rmt_pair_t node   [1:P-1];

  // Pad the leaf row out to a power of two with zeros.
  for (genvar gl = 0; gl < P; gl++) begin : g_leaf
    if (gl < N) begin : g_used
      assign leaf_w[gl] = leaf[gl];
    end else begin : g_pad
      assign leaf_w[gl] = '0;
    end
  end

  // Every level is registered; at most one leaf is nonzero.
  for (genvar gk = 1; gk < P; gk++) begin : g_node
    rmt_pair_t a;
    rmt_pair_t b;
    if (2 * gk >= P) begin : g_bottom
      assign a = leaf_w[2 * gk - P];
      assign b = leaf_w[2 * gk + 1 - P];
    end else begin : g_inner
      assign a = node[2 * gk];
      assign b = node[2 * gk + 1];
    end
    always_ff @(posedge clk) begin
      node[gk] <= a | b;
    end
  end

  assign root = node[1];

endmodule

// ----- rtl/core/running_median_tracker.sv -----
// Top level of the running median tracker: cell row, readout tree and control.
//
// Usage: samples arrive as item beats (item_valid / item_ready, payload item)
// and each one yields exactly one res beat (res_valid / res_ready, payload res)
// carrying the running median, the number of samples held and an overflow flag.
// The samples are kept in ascending order in a row of CAPACITY cells; an
// insert shifts the larger entries up one cell in the cycle of acceptance.
// The median pair is then gathered from the row through a registered OR tree
// of $clog2(CAPACITY) levels; the result is loaded once the walk through those
// levels is done, and no new item is accepted until that item's result has
// been loaded into the output register.
// Once CAPACITY samples are held, further samples are dropped and flagged.
// An item with last_item set empties the store once its result is loaded.
// Reset clears the count and the cell pointers directly; no sweep is run.
// When the receiver stalls, the finished result waits in the output register
// while one further item may be accepted and worked on; that item's result
// then waits inside until the output register is free.
module running_median_tracker #(
  parameter int CAPACITY = 1024
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_ready,
  input  rmt_pkg::rmt_in_t  item,
  output logic              res_valid,
  input  logic              res_ready,
  output rmt_pkg::rmt_out_t res
);
  import rmt_pkg::*;

  localparam int DEPTH  = $clog2(CAPACITY);
  localparam int CNT_W  = $clog2(CAPACITY + 1);
  localparam int WALK_W = $clog2(DEPTH + 1);

  rmt_state_t           state;
  rmt_state_t           state_next;
  logic [WALK_W-1:0]    walk;
  logic [CNT_W-1:0]     n;
  logic [CNT_W-1:0]     n_next;
  logic [CNT_W-1:0]     n_after;
  logic                 pend_last;
  logic                 res_odd;
  logic [COUNT_W-1:0]   res_count;
  logic                 res_ovf;

  logic                 accept;
  logic                 full;
  logic                 load;
  rmt_ctl_t             ctl;

  logic [SAMPLE_W-1:0]  val_v  [CAPACITY];
  logic [CAPACITY-1:0]  gt_v;
  logic [CAPACITY-1:0]  tail_v;
  logic [CAPACITY-1:0]  sel_v;
  rmt_pair_t            leaf_v [CAPACITY];
  rmt_pair_t            root;
  logic [SAMPLE_W:0]    mid_sum;

  assign accept  = item_valid && item_ready;
  assign full    = n == CNT_W'(CAPACITY);
  assign n_after = full ? n : n + CNT_W'(1);

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = ST_WALK;
        end
      end
      ST_WALK: begin
        if (walk == WALK_W'(DEPTH - 1)) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (load) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Control outputs.
  always_comb begin
    item_ready = 1'b0;
    load       = 1'b0;
    case (state)
      ST_IDLE: item_ready = 1'b1;
      ST_WALK: item_ready = 1'b0;
      ST_DONE: load = !res_valid || res_ready;
      default: item_ready = 1'b0;
    endcase
  end

  // The lower-middle marker moves up when the count goes to an odd value above one.
  assign ctl.insert  = accept && !full;
  assign ctl.advance = accept && !full && !n[0] && (n != '0);
  assign ctl.clear   = load && pend_last;

  always_comb begin
    n_next = n;
    if (ctl.clear) begin
      n_next = '0;
    end else if (ctl.insert) begin
      n_next = n_after;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      walk      <= '0;
      n         <= '0;
      res_valid <= 1'b0;
    end else begin
      state <= state_next;
      n     <= n_next;
      if (accept) begin
        walk <= '0;
      end else if (state == ST_WALK) begin
        walk <= walk + WALK_W'(1);
      end
      if (load) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  // Per-item facts captured at acceptance.
  always_ff @(posedge clk) begin
    if (accept) begin
      pend_last <= item.last_item;
      res_odd   <= n_after[0];
      res_count <= COUNT_W'(n_after);
      res_ovf   <= full;
    end
  end

  // Median from the gathered pair: middle entry, or floor of the mean of both.
  assign mid_sum = {1'b0, root.lo} + {1'b0, root.hi};

  always_ff @(posedge clk) begin
    if (load) begin
      res.median   <= res_odd ? root.lo : mid_sum[SAMPLE_W:1];
      res.count    <= res_count;
      res.overflow <= res_ovf;
    end
  end

  // Row of sorted cells, each linked to its two neighbors.
  for (genvar gi = 0; gi < CAPACITY; gi++) begin : g_cell
    logic [SAMPLE_W-1:0] lv;
    logic                lg;
    logic                ti;
    logic                si;
    logic [SAMPLE_W-1:0] rv;

    if (gi == 0) begin : g_head
      assign lv = '0;
      assign lg = 1'b0;
      assign ti = 1'b0;
      assign si = 1'b0;
    end else begin : g_body
      assign lv = val_v[gi-1];
      assign lg = gt_v[gi-1];
      assign ti = tail_v[gi-1];
      assign si = sel_v[gi-1];
    end

    if (gi == CAPACITY - 1) begin : g_end
      assign rv = '0;
    end else begin : g_next
      assign rv = val_v[gi+1];
    end

    rmt_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .sample    (item.sample),
      .ctl       (ctl),
      .home      (1'(gi == 0)),
      .left_val  (lv),
      .left_gt   (lg),
      .tail_in   (ti),
      .sel_in    (si),
      .right_val (rv),
      .val       (val_v[gi]),
      .gt        (gt_v[gi]),
      .tail      (tail_v[gi]),
      .sel       (sel_v[gi]),
      .leaf      (leaf_v[gi])
    );
  end

  rmt_or_tree #(
    .N (CAPACITY)
  ) u_tree (
    .clk  (clk),
    .leaf (leaf_v),
    .root (root)
  );

  // The fill pointer marks the first free cell and falls off the row when full.
  a_tail_full: assert property (@(posedge clk) disable iff (rst)
    full |-> (tail_v == '0))
    else $error("fill pointer still set while the store is full");

  a_tail_open: assert property (@(posedge clk) disable iff (rst)
    !full |-> $onehot(tail_v))
    else $error("fill pointer lost while the store has room");

  // Exactly one cell is marked as the lower middle.
  a_sel_onehot: assert property (@(posedge clk) disable iff (rst)
    $onehot(sel_v))
    else $error("lower-middle marker is not one-hot");

  // The held count never passes the row length.
  a_count_cap: assert property (@(posedge clk) disable iff (rst)
    n <= CNT_W'(CAPACITY))
    else $error("held count exceeds capacity");

endmodule

// ----- test/running_median_tracker_tb.sv -----
// Self-checking testbench for the running median tracker.
`timescale 1ns / 100ps

module running_median_tracker_tb;
  import rmt_pkg::*;

  localparam int CAP         = 1024;
  localparam int LONG_LEN    = 300;
  localparam int RANDOM_GOAL = 330;
  localparam int HOLD_AT     = 40;    // result beats seen before the long receiver hold
  localparam int HOLD_LEN    = 300;
  localparam int QUIET_LIMIT = 3000;  // cycles without any beat before the run is abandoned
  localparam int DRAIN_WAIT  = 30;

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     item_valid = 1'b0;
  logic     item_ready;
  rmt_in_t  item = '0;
  logic     res_valid;
  logic     res_ready = 1'b0;
  rmt_out_t res;

  // Stimulus waiting for the driver, and results the predictor has worked out.
  rmt_in_t  pending_items[$];
  rmt_out_t expected_medians[$];

  // Predictor copy of the sorted sample store.
  logic [SAMPLE_W-1:0] held_samples[$];

  int mismatches    = 0;
  int results_seen  = 0;
  int send_gap      = 0;
  int send_calm     = 0;
  int recv_gap      = 0;
  int recv_calm     = 0;
  int hold_left     = 0;
  bit hold_done     = 1'b0;
  int quiet_cycles  = 0;

  running_median_tracker #(
    .CAPACITY(CAP)
  ) DUT (
    .clk       (clk),
    .rst       (rst),
    .item_valid(item_valid),
    .item_ready(item_ready),
    .item      (item),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  always #5 clk = ~clk;

  // Mostly short gaps, a few long ones, and now and then a stretch with none.
  function automatic int pick_gap(inout int calm);
    int roll;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 24) == 0) begin
      calm = $urandom_range(20, 60);
    end
    roll = $urandom_range(0, 99);
    if (roll < 50) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Sample spread: full range, clustered duplicates, top end, or the two extremes.
  function automatic logic [SAMPLE_W-1:0] pick_sample(int mode);
    case (mode)
      1: pick_sample = SAMPLE_W'($urandom_range(0, 7));
      2: pick_sample = SAMPLE_W'($urandom_range(16'hFF00, 16'hFFFF));
      3: pick_sample = $urandom_range(0, 1) ? '1 : '0;
      default: pick_sample = SAMPLE_W'($urandom);
    endcase
  endfunction

  task automatic queue_item(input logic [SAMPLE_W-1:0] value, input logic is_last);
    rmt_in_t beat;
    beat.sample    = value;
    beat.last_item = is_last;
    pending_items.push_back(beat);
  endtask

  task automatic queue_stream(input int len, input int mode);
    for (int i = 0; i < len; i++) begin
      queue_item(pick_sample(mode), i == len - 1);
    end
  endtask

  // Insert the accepted sample in order and work out the running median it yields.
  task automatic predict_median(input rmt_in_t beat);
    rmt_out_t          want;
    int                pos;
    int                held;
    logic [SAMPLE_W:0] pair_sum;
    want = '0;
    if (held_samples.size() >= CAP) begin
      want.overflow = 1'b1;
    end else begin
      pos = held_samples.size();
      while (pos > 0 && held_samples[pos-1] > beat.sample) pos--;
      held_samples.insert(pos, beat.sample);
    end
    held = held_samples.size();
    if (held % 2 == 1) begin
      want.median = held_samples[held/2];
    end else begin
      pair_sum    = {1'b0, held_samples[held/2-1]} + {1'b0, held_samples[held/2]};
      want.median = pair_sum[SAMPLE_W:1];
    end
    want.count = COUNT_W'(held);
    expected_medians.push_back(want);
    if (beat.last_item) held_samples.delete();
  endtask

  // Sender: offers the next pending item after a random gap.
  always @(posedge clk) begin : drive_items
    logic offer;
    if (rst) begin
      item_valid <= 1'b0;
      item       <= '0;
    end else begin
      offer = item_valid;
      if (item_valid && item_ready) begin
        predict_median(item);
        send_gap = pick_gap(send_calm);
        offer    = 1'b0;
      end
      if (!offer) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (pending_items.size() > 0) begin
          item  <= pending_items.pop_front();
          offer = 1'b1;
        end
      end
      item_valid <= offer;
    end
  end

  // Receiver: checks each result beat and stalls at random, once for a long hold.
  always @(posedge clk) begin : check_results
    rmt_out_t want;
    logic     take;
    if (rst) begin
      res_ready <= 1'b0;
    end else begin
      if (res_valid && res_ready) begin
        results_seen++;
        recv_gap = pick_gap(recv_calm);
        if (expected_medians.size() == 0) begin
          $display("%0t: unexpected result median=%0d count=%0d overflow=%0b",
                   $time, res.median, res.count, res.overflow);
          mismatches++;
        end else begin
          want = expected_medians.pop_front();
          if (res.median !== want.median) begin
            $display("%0t: median expected %0d, got %0d", $time, want.median, res.median);
            mismatches++;
          end
          if (res.count !== want.count) begin
            $display("%0t: count expected %0d, got %0d", $time, want.count, res.count);
            mismatches++;
          end
          if (res.overflow !== want.overflow) begin
            $display("%0t: overflow expected %0b, got %0b",
                     $time, want.overflow, res.overflow);
            mismatches++;
          end
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        take = 1'b0;
      end else if (!hold_done && results_seen >= HOLD_AT) begin
        hold_done = 1'b1;
        hold_left = HOLD_LEN;
        take      = 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap--;
        take = 1'b0;
      end else begin
        take = 1'b1;
      end
      res_ready <= take;
    end
  end

  // Watchdog: give up if no beat moves on either side for too long.
  always @(posedge clk) begin
    if (rst || (item_valid && item_ready) || (res_valid && res_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("[running_median_tracker] ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic wait_drained();
    while (pending_items.size() > 0 || item_valid || expected_medians.size() > 0) begin
      @(posedge clk);
    end
  endtask

  initial begin : stimulus
    int queued;
    int len;
    int roll;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: extremes, floor of the even mean, top-end sum, descending order, duplicates.
    queue_item(16'h0000, 1'b1);
    queue_item(16'hFFFF, 1'b1);
    queue_item(16'hFFFF, 1'b0);
    queue_item(16'hFFFF, 1'b1);
    queue_item(16'h0000, 1'b0);
    queue_item(16'hFFFF, 1'b0);
    queue_item(16'h0001, 1'b1);
    for (int v = 5; v >= 1; v--) queue_item(SAMPLE_W'(v), v == 1);
    queue_item(16'h0007, 1'b0);
    queue_item(16'h0007, 1'b0);
    queue_item(16'h0007, 1'b0);
    queue_item(16'h0003, 1'b1);
    queue_item(16'h0001, 1'b0);
    queue_item(16'h0002, 1'b1);
    queue_item(16'hAAAA, 1'b0);
    queue_item(16'h5555, 1'b1);
    wait_drained();

    // One long stream; the long receiver hold falls inside it.
    queue_stream(LONG_LEN, 0);
    wait_drained();

    // Random streams of varied length and sample spread.
    queued = 0;
    while (queued < RANDOM_GOAL) begin
      roll = $urandom_range(0, 99);
      if (roll < 60) len = $urandom_range(1, 8);
      else if (roll < 90) len = $urandom_range(9, 40);
      else len = $urandom_range(41, 150);
      queue_stream(len, $urandom_range(0, 3));
      queued += len;
    end
    wait_drained();

    repeat (DRAIN_WAIT) @(posedge clk);
    if (mismatches == 0 && expected_medians.size() == 0) begin
      $display("[running_median_tracker] OK");
    end else begin
      $display("[running_median_tracker] ERROR");
    end
    $finish;
  end

endmodule
